FILE: sv/tkvs_pkg.sv
// Package for the top-K value selector: sizes, state encoding, and the
// control struct shared by the controller and the cell chain.
// No dependencies.
package tkvs_pkg;

   localparam int MAX_KEEP   = 16;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 16;
   localparam int RANK_W     = 4;
   localparam int KEEP_CFG_W = 5;
   localparam int KEEP_RESET = 16;

   // entry count holds 0..MAX_KEEP, rank counter spans the same range
   localparam int CNT_W = $clog2(MAX_KEEP + 1);
   localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   // width able to hold both the config field and MAX_KEEP
   localparam int KW    = (CNT_W > KEEP_CFG_W) ? CNT_W : KEEP_CFG_W;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_REPORT
   } tkvs_state_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;     // a new value is presented for insertion
      logic shift_out;  // chain moves one step toward cell 0 for the report
   } tkvs_cell_ctl_type;

endpackage

FILE: sv/top_k_value_selector_core.sv
// Top level of the top-K value selector: controller, config register,
// result register and the chain of tkvs_cell instances.
// Depends on tkvs_pkg and tkvs_cell.
// A request is inserted in the cycle it is accepted. After the last request
//   of a group the state register moves to report; the result register then
//   takes results one per cycle unless rsp_ready stalls. Throughput: one
//   request per cycle while a group is collected, none while it reports.
// Reset: fill count, position counter, report counters, result valid and state cleared, keep_count = 16.
module top_k_value_selector_core
   import tkvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [KEEP_CFG_W-1:0] csr_keep_count,
   // requests
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_W-1:0]    req_sample_value,
   input  logic                  req_last_in_group,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RANK_W-1:0]     rsp_rank,
   output logic [POS_W-1:0]      rsp_position,
   output logic [VALUE_W-1:0]    rsp_kept_value,
   output logic                  rsp_last_of_run
);

   tkvs_state_type    state_ff, state_in;
   tkvs_cell_ctl_type cell_ctl;

   logic [KEEP_CFG_W-1:0] keep_ff;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [POS_W-1:0]      pcount_ff, pcount_in;
   logic [CNT_W-1:0]      rpt_count_ff, rpt_count_in;
   logic [CNT_W-1:0]      rpt_index_ff, rpt_index_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]     rsp_rank_ff;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic                  rsp_last_ff;

   logic [KW-1:0]         keep_wide;
   logic [CNT_W-1:0]      eff_k;
   logic [CNT_W-1:0]      n_used;
   logic                  req_fire;
   logic                  out_free;
   logic                  room;
   logic                  rpt_last;

   logic [MAX_KEEP-1:0]   greater;
   logic [MAX_KEEP-1:0]   beyond_fill;
   logic [VALUE_W-1:0]    cell_value [MAX_KEEP];
   logic [POS_W-1:0]      cell_pos   [MAX_KEEP];

   // configuration is always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= KEEP_CFG_W'(KEEP_RESET);
      end else if (csr_valid) begin
         keep_ff <= csr_keep_count;
      end
   end

   // effective K: zero reads as one, clamp to the chain length
   always_comb begin
      keep_wide = KW'(keep_ff);
      if (keep_wide == '0) begin
         keep_wide = KW'(1);
      end else if (keep_wide > KW'(MAX_KEEP)) begin
         keep_wide = KW'(MAX_KEEP);
      end
      eff_k = CNT_W'(keep_wide);
   end

   // held entries that still count after a lowered K
   assign n_used = (fill_ff > eff_k) ? eff_k : fill_ff;

   always_comb begin
      for (int i = 0; i < MAX_KEEP; i++) begin
         beyond_fill[i] = (CNT_W'(i) >= n_used);
      end
   end

   // new value lands inside the first K cells
   assign room = greater[IDX_W'(eff_k - CNT_W'(1))];

   assign req_fire = req_valid & req_ready;
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign rpt_last = (rpt_index_ff + CNT_W'(1)) == rpt_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_fire && req_last_in_group) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free && rpt_last) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready          = 1'b0;
      cell_ctl.insert    = 1'b0;
      cell_ctl.shift_out = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready       = 1'b1;
            cell_ctl.insert = req_valid;
         end
         ST_REPORT: begin
            cell_ctl.shift_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // fill count, position counter and report counters
   always_comb begin
      fill_in      = fill_ff;
      pcount_in    = pcount_ff;
      rpt_count_in = rpt_count_ff;
      rpt_index_in = rpt_index_ff;
      if (req_fire) begin
         if (room) begin
            fill_in = (n_used < eff_k) ? n_used + CNT_W'(1) : eff_k;
         end else begin
            fill_in = n_used;
         end
         pcount_in = (pcount_ff == POS_MAX) ? pcount_ff : pcount_ff + POS_W'(1);
         if (req_last_in_group) begin
            rpt_count_in = fill_in;
            rpt_index_in = '0;
            fill_in      = '0;
            pcount_in    = '0;
         end
      end else if (cell_ctl.shift_out) begin
         rpt_index_in = rpt_index_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         fill_ff      <= '0;
         pcount_ff    <= '0;
         rpt_count_ff <= '0;
         rpt_index_ff <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pcount_ff    <= pcount_in;
         rpt_count_ff <= rpt_count_in;
         rpt_index_ff <= rpt_index_in;
      end
   end

   // result register: loaded from the head cell during the report
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cell_ctl.shift_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_ctl.shift_out) begin
         rsp_rank_ff  <= RANK_W'(rpt_index_ff);
         rsp_pos_ff   <= cell_pos[0];
         rsp_value_ff <= cell_value[0];
         rsp_last_ff  <= rpt_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_kept_value  = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // sorted chain, cell 0 holds the largest value
   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
      logic               prev_greater;
      logic [VALUE_W-1:0] prev_value, next_value;
      logic [POS_W-1:0]   prev_pos, next_pos;

      if (g == 0) begin : g_head
         assign prev_greater = 1'b0;
         assign prev_value   = '0;
         assign prev_pos     = '0;
      end else begin : g_body
         assign prev_greater = greater[g-1];
         assign prev_value   = cell_value[g-1];
         assign prev_pos     = cell_pos[g-1];
      end

      if (g == MAX_KEEP - 1) begin : g_tail
         assign next_value = '0;
         assign next_pos   = '0;
      end else begin : g_inner
         assign next_value = cell_value[g+1];
         assign next_pos   = cell_pos[g+1];
      end

      tkvs_cell u_cell (
         .clock        (clock),
         .ctl          (cell_ctl),
         .new_value    (req_sample_value),
         .new_pos      (pcount_ff),
         .beyond_fill  (beyond_fill[g]),
         .prev_greater (prev_greater),
         .prev_value   (prev_value),
         .prev_pos     (prev_pos),
         .next_value   (next_value),
         .next_pos     (next_pos),
         .greater      (greater[g]),
         .value        (cell_value[g]),
         .pos          (cell_pos[g])
      );
   end

endmodule

FILE: sv/tkvs_cell.sv
// One cell of the sorted chain: holds a value and its position.
// Depends on tkvs_pkg.
module tkvs_cell
   import tkvs_pkg::*;
(
   input  logic                 clock,
   input  tkvs_cell_ctl_type    ctl,
   input  logic [VALUE_W-1:0]   new_value,
   input  logic [POS_W-1:0]     new_pos,
   input  logic                 beyond_fill,   // this cell holds no valid entry
   input  logic                 prev_greater,  // upper neighbor gives way to new value
   input  logic [VALUE_W-1:0]   prev_value,
   input  logic [POS_W-1:0]     prev_pos,
   input  logic [VALUE_W-1:0]   next_value,
   input  logic [POS_W-1:0]     next_pos,
   output logic                 greater,
   output logic [VALUE_W-1:0]   value,
   output logic [POS_W-1:0]     pos
);

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   // strictly greater wins, so equal values keep arrival order
   assign greater = beyond_fill | (new_value > value_ff);

   // next entry: report shift, take neighbor's entry, take new value, or hold
   always_comb begin
      value_in = value_ff;
      pos_in   = pos_ff;
      if (ctl.shift_out) begin
         value_in = next_value;
         pos_in   = next_pos;
      end else if (ctl.insert) begin
         if (prev_greater) begin
            value_in = prev_value;
            pos_in   = prev_pos;
         end else if (greater) begin
            value_in = new_value;
            pos_in   = new_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign value = value_ff;
   assign pos   = pos_ff;

endmodule
